/* rtl/kowq_pkg.sv */
package kowq_pkg;

  localparam int unsigned CMD_W     = 3;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned IN_NAME_W = 64;
  localparam int unsigned PHONE_W   = 16;
  localparam int unsigned RI_W      = 4;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND   = 3'd0,
    CMD_POP      = 3'd1,
    CMD_SEARCH   = 3'd2,
    CMD_POSTPONE = 3'd3,
    CMD_CANCEL   = 3'd4,
    CMD_READ     = 3'd5
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_FULL      = 3'd3,
    ST_NO_MOVE   = 3'd4
  } status_e;

  // write data source
  typedef enum logic [1:0] {
    WSRC_INPUT,
    WSRC_RDATA,
    WSRC_HOLD
  } wsrc_e;

  // write address source
  typedef enum logic [1:0] {
    WA_COUNT,
    WA_PREV_M1,
    WA_MARK,
    WA_MARK1
  } waddr_e;

  // reported position
  typedef enum logic [1:0] {
    POS_NONE,
    POS_MARK1,
    POS_MARK2
  } pos_e;

  typedef struct packed {
    logic    load_in;
    logic    addr_zero;
    logic    addr_ri;
    logic    rd_issue;
    logic    capture;
    logic    wr_en;
    wsrc_e   wsrc;
    waddr_e  wa;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    out_load;
    status_e res_status;
    pos_e    res_pos;
  } ctl_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             empty;
    logic             full;
    logic             lt2;
    logic             ri_ge_cnt;
    logic             hit;
    logic             rvalid;
    logic             at_lim;
    logic             at_cnt;
    logic             out_free;
  } ctl_sts_t;

endpackage

/* rtl/keyed_ordered_wait_queue.sv */
// Channel  Dir  tdata (low bit up)                          tuser
// s_axis   in   entry_name 64, key_phone 16, read_index 4     cmd 3
// m_axis   out  out_name 64, out_phone 16, position, count    status 3
//
// One item at a time, N entries held. Search, pop, cancel and postpone scan the entry
// store one entry a cycle through its single read port, and pop and cancel then shift
// the entries down one entry a cycle through its single write port. Reset empties the
// queue; store contents are not cleared. A result waiting on m_axis holds the next
// item in its last cycle.
module keyed_ordered_wait_queue import kowq_pkg::*; #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned NAME_BYTES = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // entry_name [63:0], key_phone [79:64], read_index [83:80], zero pad
  input  logic [((IN_NAME_W+PHONE_W+RI_W+7)/8)*8-1:0] s_axis_tdata,
  // cmd [2:0]
  input  logic [CMD_W-1:0]    s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // out_name [63:0], out_phone [79:64], position, entry_count, zero pad
  output logic [((IN_NAME_W+PHONE_W+2*$clog2(DEPTH+1)+7)/8)*8-1:0] m_axis_tdata,
  // status [2:0]
  output logic [STATUS_W-1:0] m_axis_tuser
);

  localparam int unsigned CNT_W    = $clog2(DEPTH + 1);
  localparam int unsigned OUT_W    = IN_NAME_W + PHONE_W + 2 * CNT_W;
  localparam int unsigned M_DATA_W = ((OUT_W + 7) / 8) * 8;

  ctl_cmd_t             cmd;
  ctl_sts_t             sts;
  logic [IN_NAME_W-1:0] out_name;
  logic [PHONE_W-1:0]   out_phone;
  logic [CNT_W-1:0]     out_pos;
  logic [CNT_W-1:0]     out_count;

  kowq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  kowq_dpath #(
    .DEPTH      (DEPTH),
    .NAME_BYTES (NAME_BYTES)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .in_cmd_i     (s_axis_tuser),
    .in_name_i    (s_axis_tdata[IN_NAME_W-1:0]),
    .in_phone_i   (s_axis_tdata[IN_NAME_W+PHONE_W-1:IN_NAME_W]),
    .in_ri_i      (s_axis_tdata[IN_NAME_W+PHONE_W+RI_W-1:IN_NAME_W+PHONE_W]),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_status_o (m_axis_tuser),
    .out_name_o   (out_name),
    .out_phone_o  (out_phone),
    .out_pos_o    (out_pos),
    .out_count_o  (out_count)
  );

  assign m_axis_tdata = M_DATA_W'({out_count, out_pos, out_phone, out_name});

  // one item in flight: no accept right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("second beat accepted while an item is in progress");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (out_count <= CNT_W'(DEPTH)))
    else $error("entry count above capacity");

  // a refused command reports no entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser != ST_OK)) |->
      ((out_pos == '0) && (out_name == '0) && (out_phone == '0)))
    else $error("entry reported with a failing status");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((CNT_W+1)'(out_pos) <= (CNT_W+1)'(out_count) + (CNT_W+1)'(1)))
    else $error("position beyond the queue");

endmodule

/* rtl/kowq_ram.sv */
module kowq_ram #(
  parameter int unsigned WIDTH = 80,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/kowq_ctrl.sv */
module kowq_ctrl import kowq_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  ctl_sts_t sts_i,
  output ctl_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_SHIFT,
    S_SWAP_RD,
    S_SWAP_W0,
    S_SWAP_W1,
    S_FETCH0,
    S_FETCH1,
    S_RESP
  } state_e;

  state_e  state_q, state_d;
  status_e status_q, status_d;
  pos_e    pos_q, pos_d;

  always_comb begin
    state_d  = state_q;
    status_d = status_q;
    pos_d    = pos_q;

    cmd_o.load_in    = 1'b0;
    cmd_o.addr_zero  = 1'b0;
    cmd_o.addr_ri    = 1'b0;
    cmd_o.rd_issue   = 1'b0;
    cmd_o.capture    = 1'b0;
    cmd_o.wr_en      = 1'b0;
    cmd_o.wsrc       = WSRC_RDATA;
    cmd_o.wa         = WA_PREV_M1;
    cmd_o.cnt_inc    = 1'b0;
    cmd_o.cnt_dec    = 1'b0;
    cmd_o.out_load   = 1'b0;
    cmd_o.res_status = status_q;
    cmd_o.res_pos    = pos_q;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = S_DECODE;
        end
      end

      S_DECODE: begin
        status_d = ST_OK;
        pos_d    = POS_NONE;
        state_d  = S_RESP;
        case (sts_i.cmd)
          CMD_APPEND: begin
            if (sts_i.full) begin
              status_d = ST_FULL;
            end else begin
              cmd_o.wr_en   = 1'b1;
              cmd_o.wsrc    = WSRC_INPUT;
              cmd_o.wa      = WA_COUNT;
              cmd_o.cnt_inc = 1'b1;
            end
          end
          CMD_POP, CMD_SEARCH, CMD_CANCEL: begin
            if (sts_i.empty) begin
              status_d = ST_EMPTY;
            end else begin
              cmd_o.addr_zero = 1'b1;
              state_d         = S_SCAN;
            end
          end
          CMD_POSTPONE: begin
            if (sts_i.lt2) begin
              status_d = ST_NO_MOVE;
            end else begin
              cmd_o.addr_zero = 1'b1;
              state_d         = S_SCAN;
            end
          end
          CMD_READ: begin
            if (sts_i.empty) begin
              status_d = ST_EMPTY;
            end else if (sts_i.ri_ge_cnt) begin
              status_d = ST_NOT_FOUND;
            end else begin
              cmd_o.addr_ri = 1'b1;
              state_d       = S_FETCH0;
            end
          end
          default: begin
            state_d = S_RESP;
          end
        endcase
      end

      // one read issued per cycle, each compared in the cycle after its issue
      S_SCAN: begin
        if (sts_i.hit) begin
          cmd_o.capture = 1'b1;
          status_d      = ST_OK;
          pos_d         = POS_MARK1;
          if (sts_i.cmd == CMD_POSTPONE) begin
            state_d = S_SWAP_RD;
          end else if (sts_i.cmd inside {CMD_POP, CMD_CANCEL}) begin
            state_d = S_SHIFT;
          end else begin
            state_d = S_RESP;
          end
        end else if (sts_i.at_lim) begin
          status_d = ST_NOT_FOUND;
          pos_d    = POS_NONE;
          state_d  = S_RESP;
        end else begin
          cmd_o.rd_issue = 1'b1;
        end
      end

      // close the gap: read one ahead, write it back one place lower
      S_SHIFT: begin
        cmd_o.wr_en = sts_i.rvalid;
        cmd_o.wsrc  = WSRC_RDATA;
        cmd_o.wa    = WA_PREV_M1;
        if (sts_i.at_cnt) begin
          cmd_o.cnt_dec = 1'b1;
          state_d       = S_RESP;
        end else begin
          cmd_o.rd_issue = 1'b1;
        end
      end

      S_SWAP_RD: begin
        cmd_o.rd_issue = 1'b1;
        state_d        = S_SWAP_W0;
      end

      S_SWAP_W0: begin
        cmd_o.wr_en = 1'b1;
        cmd_o.wsrc  = WSRC_RDATA;
        cmd_o.wa    = WA_MARK;
        state_d     = S_SWAP_W1;
      end

      S_SWAP_W1: begin
        cmd_o.wr_en = 1'b1;
        cmd_o.wsrc  = WSRC_HOLD;
        cmd_o.wa    = WA_MARK1;
        pos_d       = POS_MARK2;
        state_d     = S_RESP;
      end

      S_FETCH0: begin
        cmd_o.rd_issue = 1'b1;
        state_d        = S_FETCH1;
      end

      S_FETCH1: begin
        cmd_o.capture = 1'b1;
        status_d      = ST_OK;
        pos_d         = POS_MARK1;
        state_d       = S_RESP;
      end

      S_RESP: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      status_q <= ST_OK;
      pos_q    <= POS_NONE;
    end else begin
      state_q  <= state_d;
      status_q <= status_d;
      pos_q    <= pos_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

endmodule

/* rtl/kowq_dpath.sv */
module kowq_dpath import kowq_pkg::*; #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned NAME_BYTES = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  ctl_cmd_t                       cmd_i,
  output ctl_sts_t                       sts_o,
  input  logic [CMD_W-1:0]               in_cmd_i,
  input  logic [IN_NAME_W-1:0]           in_name_i,
  input  logic [PHONE_W-1:0]             in_phone_i,
  input  logic [RI_W-1:0]                in_ri_i,
  input  logic                           out_ready_i,
  output logic                           out_valid_o,
  output logic [STATUS_W-1:0]            out_status_o,
  output logic [IN_NAME_W-1:0]           out_name_o,
  output logic [PHONE_W-1:0]             out_phone_o,
  output logic [$clog2(DEPTH+1)-1:0]     out_pos_o,
  output logic [$clog2(DEPTH+1)-1:0]     out_count_o
);

  localparam int unsigned NAME_W = 8 * NAME_BYTES;
  localparam int unsigned AW     = $clog2(DEPTH);
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned ENT_W  = NAME_W + PHONE_W;
  localparam int unsigned CMP_W  = CNT_W + RI_W;

  logic [CMD_W-1:0]     cmd_q;
  logic [NAME_W-1:0]    name_q;
  logic [PHONE_W-1:0]   phone_q;
  logic [RI_W-1:0]      ri_q;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [CNT_W-1:0]     addr_q, addr_d;
  logic [AW-1:0]        prev_q;
  logic                 rvalid_q;
  logic [AW-1:0]        mark_q;
  logic [NAME_W-1:0]    hold_name_q;
  logic [PHONE_W-1:0]   hold_phone_q;

  logic                 ovalid_q;
  logic [STATUS_W-1:0]  ostatus_q;
  logic [IN_NAME_W-1:0] oname_q;
  logic [PHONE_W-1:0]   ophone_q;
  logic [CNT_W-1:0]     opos_q, opos_d;
  logic [CNT_W-1:0]     ocnt_q;

  logic [ENT_W-1:0]     rdata;
  logic [NAME_W-1:0]    rd_name;
  logic [PHONE_W-1:0]   rd_phone;
  logic [ENT_W-1:0]     wdata;
  logic [AW-1:0]        waddr;
  logic [CNT_W-1:0]     lim;
  logic                 match;

  assign rd_name  = rdata[ENT_W-1:PHONE_W];
  assign rd_phone = rdata[PHONE_W-1:0];

  always_comb begin
    case (cmd_i.wsrc)
      WSRC_INPUT: wdata = {name_q, phone_q};
      WSRC_HOLD:  wdata = {hold_name_q, hold_phone_q};
      default:    wdata = rdata;
    endcase
  end

  always_comb begin
    case (cmd_i.wa)
      WA_COUNT: waddr = cnt_q[AW-1:0];
      WA_MARK:  waddr = mark_q;
      WA_MARK1: waddr = AW'(mark_q + AW'(1));
      default:  waddr = AW'(prev_q - AW'(1));
    endcase
  end

  kowq_ram #(
    .WIDTH (ENT_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_en),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (cmd_i.rd_issue),
    .raddr_i (addr_q[AW-1:0]),
    .rdata_o (rdata)
  );

  always_comb begin
    case (cmd_q)
      CMD_POP:                match = 1'b1;
      CMD_SEARCH, CMD_CANCEL: match = (rd_phone == phone_q);
      CMD_POSTPONE:           match = (rd_name == name_q);
      default:                match = 1'b0;
    endcase
  end

  // postpone never picks the last entry
  assign lim = (cmd_q == CMD_POSTPONE) ? CNT_W'(cnt_q - CNT_W'(1)) : cnt_q;

  assign sts_o.cmd       = cmd_q;
  assign sts_o.empty     = (cnt_q == '0);
  assign sts_o.full      = (cnt_q >= CNT_W'(DEPTH));
  assign sts_o.lt2       = (cnt_q < CNT_W'(2));
  assign sts_o.ri_ge_cnt = (CMP_W'(ri_q) >= CMP_W'(cnt_q));
  assign sts_o.hit       = rvalid_q && match;
  assign sts_o.rvalid    = rvalid_q;
  assign sts_o.at_lim    = (addr_q >= lim);
  assign sts_o.at_cnt    = (addr_q >= cnt_q);
  assign sts_o.out_free  = !ovalid_q || out_ready_i;

  always_comb begin
    addr_d = addr_q;
    if (cmd_i.capture) begin
      addr_d = CNT_W'(prev_q) + CNT_W'(1);
    end else if (cmd_i.addr_zero) begin
      addr_d = '0;
    end else if (cmd_i.addr_ri) begin
      addr_d = CNT_W'(ri_q);
    end else if (cmd_i.rd_issue) begin
      addr_d = addr_q + CNT_W'(1);
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.cnt_inc) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (cmd_i.cnt_dec) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_comb begin
    case (cmd_i.res_pos)
      POS_MARK1: opos_d = CNT_W'(mark_q) + CNT_W'(1);
      POS_MARK2: opos_d = CNT_W'(mark_q) + CNT_W'(2);
      default:   opos_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      rvalid_q <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      cnt_q    <= cnt_d;
      rvalid_q <= cmd_i.rd_issue;
      if (cmd_i.out_load) begin
        ovalid_q <= 1'b1;
      end else if (out_ready_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      cmd_q   <= in_cmd_i;
      name_q  <= in_name_i[NAME_W-1:0];
      phone_q <= in_phone_i;
      ri_q    <= in_ri_i;
    end
    addr_q <= addr_d;
    if (cmd_i.rd_issue) begin
      prev_q <= addr_q[AW-1:0];
    end
    if (cmd_i.capture) begin
      mark_q       <= prev_q;
      hold_name_q  <= rd_name;
      hold_phone_q <= rd_phone;
    end
    if (cmd_i.out_load) begin
      ostatus_q <= cmd_i.res_status;
      opos_q    <= opos_d;
      ocnt_q    <= cnt_q;
      if (cmd_i.res_pos == POS_NONE) begin
        oname_q  <= '0;
        ophone_q <= '0;
      end else begin
        oname_q  <= IN_NAME_W'(hold_name_q);
        ophone_q <= hold_phone_q;
      end
    end
  end

  assign out_valid_o  = ovalid_q;
  assign out_status_o = ostatus_q;
  assign out_name_o   = oname_q;
  assign out_phone_o  = ophone_q;
  assign out_pos_o    = opos_q;
  assign out_count_o  = ocnt_q;

endmodule
